@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the receive framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition");

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

@@ rtl/mrsf_pkg.sv @@
// Package of the receive framer: sizes, codes, types and helper functions.
package mrsf_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int TIMER_BITS  = 16;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LIMIT_W     = 16;
  localparam int CMP_W       = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  localparam logic [7:0]         SLAVE_ADDR_RST = 8'd1;
  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST  = LIMIT_W'(3580);
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = LIMIT_W'(6445);

  typedef enum logic [2:0] {
    OP_RX_BYTE  = 3'd0,
    OP_TICK     = 3'd1,
    OP_TX_BEGIN = 3'd2,
    OP_TX_END   = 3'd3,
    OP_READ     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_GAP_LIMIT  = 2'd1,
    CFG_IDLE_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    M_ROUNDTRIP  = 4'b0001,
    M_FRAMESTART = 4'b0010,
    M_RECEIVING  = 4'b0100,
    M_TRANSMIT   = 4'b1000
  } mode_t;

  localparam logic [1:0] MODE_CODE_ROUNDTRIP  = 2'd0;
  localparam logic [1:0] MODE_CODE_FRAMESTART = 2'd1;
  localparam logic [1:0] MODE_CODE_RECEIVING  = 2'd2;
  localparam logic [1:0] MODE_CODE_TRANSMIT   = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic             frame_done;
    logic [CNT_W-1:0] frame_bytes;
    logic             frame_dropped;
    logic             tx_granted;
    logic             read_valid;
    logic [CNT_W-1:0] available;
  } res_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      M_FRAMESTART: c = MODE_CODE_FRAMESTART;
      M_RECEIVING:  c = MODE_CODE_RECEIVING;
      M_TRANSMIT:   c = MODE_CODE_TRANSMIT;
      default:      c = MODE_CODE_ROUNDTRIP;
    endcase
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(STORE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

@@ rtl/modbus_rtu_slave_rx_framer_unit.sv @@
// Top level of the Modbus RTU slave receive framer.
//
//   channel  direction  handshake          contents
//   in_      input      in_valid/in_stall  op, rx_data, framing_error, parity_error
//   out_     output     out_valid/out_stall mode, frame flags, read byte, available
//   cfg_     input      cfg_valid/cfg_ready slave address, gap limit, idle limit
//
// One transaction is taken per cycle while in_stall is low; each gives one result
// via the wait stage and the output register. The byte store is a 512-entry RAM
// with registered read data; the extra result stage waits for its read data.
// State updates the cycle a transaction is taken. Reset is synchronous and needs
// no clearing pass. A stalled output holds two results before in_stall rises.
module modbus_rtu_slave_rx_framer_unit
  import mrsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [7:0]       in_rx_data,
  input  logic             in_framing_error,
  input  logic             in_parity_error,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_mode,
  output logic             out_frame_done,
  output logic [CNT_W-1:0] out_frame_bytes,
  output logic             out_frame_dropped,
  output logic             out_tx_granted,
  output logic             out_read_valid,
  output logic [7:0]       out_read_data,
  output logic [CNT_W-1:0] out_available,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  logic             accept;
  res_t             res;
  res_t             out_res;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  mrsf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .op            (in_op),
    .rx_data       (in_rx_data),
    .framing_error (in_framing_error),
    .parity_error  (in_parity_error),
    .res           (res),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr)
  );

  mrsf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrsf_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .res           (res),
    .ram_rdata     (ram_rdata),
    .out_stall     (out_stall),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_res       (out_res),
    .out_read_data (out_read_data)
  );

  assign out_mode          = out_res.mode;
  assign out_frame_done    = out_res.frame_done;
  assign out_frame_bytes   = out_res.frame_bytes;
  assign out_frame_dropped = out_res.frame_dropped;
  assign out_tx_granted    = out_res.tx_granted;
  assign out_read_valid    = out_res.read_valid;
  assign out_available     = out_res.available;

endmodule

@@ rtl/mrsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mrsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mrsf_ctrl.sv @@
// Framer control: configuration, mode, gap timer, pointers, counts and store access.
`include "assert_macros.svh"
module mrsf_ctrl
  import mrsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               accept,
  input  logic [2:0]         op,
  input  logic [7:0]         rx_data,
  input  logic               framing_error,
  input  logic               parity_error,
  output res_t               res,
  output logic               ram_we,
  output logic [PTR_W-1:0]   ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic               ram_re,
  output logic [PTR_W-1:0]   ram_raddr
);

  logic [7:0]            addr_r;
  logic [LIMIT_W-1:0]    gap_r;
  logic [LIMIT_W-1:0]    idle_r;

  mode_t                 mode_r, mode_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  running_r, running_nxt;
  logic                  late_r, late_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [PTR_W-1:0]      rp_r, rp_nxt;
  logic [CNT_W-1:0]      comm_r, comm_nxt;
  logic [CNT_W-1:0]      pend_r, pend_nxt;

  logic [CNT_W:0]        fill_sum;
  logic                  store_full;
  logic [CNT_W:0]        wp_back;
  logic [CNT_W:0]        wp_back_wrap;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  store_en;
  logic                  read_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= SLAVE_ADDR_RST;
      gap_r  <= GAP_LIMIT_RST;
      idle_r <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: addr_r <= cfg_data[7:0];
        CFG_GAP_LIMIT:  gap_r  <= cfg_data[LIMIT_W-1:0];
        CFG_IDLE_LIMIT: idle_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign fill_sum     = {1'b0, comm_r} + {1'b0, pend_r};
  assign store_full   = fill_sum >= (CNT_W + 1)'(STORE_DEPTH);
  assign wp_back      = (CNT_W + 1)'(wp_r) + (CNT_W + 1)'(STORE_DEPTH) - {1'b0, pend_r};
  assign wp_back_wrap = (wp_back >= (CNT_W + 1)'(STORE_DEPTH))
                        ? wp_back - (CNT_W + 1)'(STORE_DEPTH) : wp_back;
  assign timer_inc    = timer_r + TIMER_BITS'(1);

  always_comb begin
    mode_nxt          = mode_r;
    timer_nxt         = timer_r;
    running_nxt       = running_r;
    late_nxt          = late_r;
    wp_nxt            = wp_r;
    rp_nxt            = rp_r;
    comm_nxt          = comm_r;
    pend_nxt          = pend_r;
    store_en          = 1'b0;
    read_en           = 1'b0;
    res.frame_done    = 1'b0;
    res.frame_bytes   = '0;
    res.frame_dropped = 1'b0;
    res.tx_granted    = 1'b0;
    res.read_valid    = 1'b0;
    case (op)
      OP_RX_BYTE: begin
        timer_nxt   = '0;
        running_nxt = 1'b1;
        if (mode_r == M_FRAMESTART || mode_r == M_RECEIVING) begin
          if (late_r || framing_error || parity_error || store_full) begin
            wp_nxt            = wp_back_wrap[PTR_W-1:0];
            pend_nxt          = '0;
            mode_nxt          = M_ROUNDTRIP;
            late_nxt          = 1'b0;
            res.frame_dropped = 1'b1;
          end else if (mode_r == M_FRAMESTART) begin
            if (rx_data == addr_r) begin
              store_en = 1'b1;
              mode_nxt = M_RECEIVING;
            end else begin
              mode_nxt = M_ROUNDTRIP;
            end
          end else begin
            store_en = 1'b1;
          end
        end
        if (store_en) begin
          wp_nxt   = ptr_next(wp_r);
          pend_nxt = pend_r + CNT_W'(1);
        end
      end
      OP_TICK: begin
        if (running_r) begin
          timer_nxt = timer_inc;
          if (CMP_W'(timer_inc) == CMP_W'(gap_r)) begin
            late_nxt = 1'b1;
          end
          if (CMP_W'(timer_inc) == CMP_W'(idle_r)) begin
            res.frame_done  = 1'b1;
            res.frame_bytes = pend_r;
            comm_nxt        = fill_sum[CNT_W-1:0];
            pend_nxt        = '0;
            mode_nxt        = M_FRAMESTART;
            running_nxt     = 1'b0;
            late_nxt        = 1'b0;
          end
        end
      end
      OP_TX_BEGIN: begin
        if (mode_r == M_FRAMESTART) begin
          mode_nxt       = M_TRANSMIT;
          res.tx_granted = 1'b1;
        end
      end
      OP_TX_END: begin
        if (mode_r == M_TRANSMIT) begin
          late_nxt    = 1'b0;
          timer_nxt   = '0;
          running_nxt = 1'b1;
          mode_nxt    = M_ROUNDTRIP;
        end
      end
      OP_READ: begin
        if (comm_r != '0) begin
          read_en        = 1'b1;
          res.read_valid = 1'b1;
          rp_nxt         = ptr_next(rp_r);
          comm_nxt       = comm_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        comm_nxt = '0;
        pend_nxt = '0;
        rp_nxt   = '0;
        wp_nxt   = '0;
      end
      default: ;
    endcase
    res.mode      = mode_code(mode_nxt);
    res.available = comm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_ROUNDTRIP;
      timer_r   <= '0;
      running_r <= 1'b1;
      late_r    <= 1'b0;
      wp_r      <= '0;
      rp_r      <= '0;
      comm_r    <= '0;
      pend_r    <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      timer_r   <= timer_nxt;
      running_r <= running_nxt;
      late_r    <= late_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      comm_r    <= comm_nxt;
      pend_r    <= pend_nxt;
    end
  end

  assign ram_we    = accept && store_en;
  assign ram_waddr = wp_r;
  assign ram_wdata = rx_data;
  assign ram_re    = accept && read_en;
  assign ram_raddr = rp_r;

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_sum <= (CNT_W + 1)'(STORE_DEPTH))
  `ASSERT_IMPLIES(a_pend_only_rx, clk, rst_n, mode_r != M_RECEIVING, pend_r == '0)
  `ASSERT_IMPLIES(a_timer_stop, clk, rst_n, !running_r,
                  mode_r == M_FRAMESTART || mode_r == M_TRANSMIT)

endmodule

@@ rtl/mrsf_outq.sv @@
// Result pipeline: one stage waiting for store read data, then the output register.
module mrsf_outq
  import mrsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  res_t             res,
  input  logic [7:0]       ram_rdata,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output res_t             out_res,
  output logic [7:0]       out_read_data
);

  logic       p_valid_r, p_valid_nxt;
  res_t       p_res_r;
  logic       o_valid_r, o_valid_nxt;
  res_t       o_res_r;
  logic [7:0] o_data_r;
  logic       o_free;
  logic       p_adv;

  assign o_free   = !o_valid_r || !out_stall;
  assign p_adv    = p_valid_r && o_free;
  assign in_stall = p_valid_r && !o_free;

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (accept) begin
      p_valid_nxt = 1'b1;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (p_adv) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res_r <= res;
    end
    if (p_adv) begin
      o_res_r  <= p_res_r;
      o_data_r <= p_res_r.read_valid ? ram_rdata : 8'd0;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_res       = o_res_r;
  assign out_read_data = o_data_r;

endmodule

@@ test/framer_checker.sv @@
// Checker for the receive framer: tracks config writes, predicts each result and compares it.
module framer_checker
  import mrsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [7:0]       in_rx_data,
  input  logic             in_framing_error,
  input  logic             in_parity_error,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_mode,
  input  logic             out_frame_done,
  input  logic [CNT_W-1:0] out_frame_bytes,
  input  logic             out_frame_dropped,
  input  logic             out_tx_granted,
  input  logic             out_read_valid,
  input  logic [7:0]       out_read_data,
  input  logic [CNT_W-1:0] out_available,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       mode;
    logic             done;
    logic [CNT_W-1:0] nbytes;
    logic             dropped;
    logic             granted;
    logic             rvalid;
    logic [7:0]       rdata;
    logic [CNT_W-1:0] avail;
  } framer_status_t;

  logic [7:0]            addr_reg;
  logic [LIMIT_W-1:0]    gap_reg;
  logic [LIMIT_W-1:0]    idle_reg;
  logic [1:0]            link_mode;
  logic [TIMER_BITS-1:0] gap_count;
  logic                  counting;
  logic                  late;
  logic [7:0]            frame_mem [STORE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  int                    committed;
  int                    pending;
  framer_status_t        predicted_status_q[$];

  function automatic string show(input framer_status_t s);
    return $sformatf("mode %0d done %0b bytes %0d drop %0b grant %0b read %0b/%02h avail %0d",
                     s.mode, s.done, s.nbytes, s.dropped, s.granted, s.rvalid, s.rdata,
                     s.avail);
  endfunction

  task automatic restore_reset_state();
    addr_reg  = SLAVE_ADDR_RST;
    gap_reg   = GAP_LIMIT_RST;
    idle_reg  = IDLE_LIMIT_RST;
    link_mode = MODE_CODE_ROUNDTRIP;
    gap_count = '0;
    counting  = 1'b1;
    late      = 1'b0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    wr_ptr    = '0;
    rd_ptr    = '0;
    committed = 0;
    pending   = 0;
  endtask

  task automatic apply_bus_event(input logic [2:0] op, input logic [7:0] data,
                                 input logic fe, input logic pe,
                                 output framer_status_t st);
    st = '0;
    case (op)
      OP_RX_BYTE: begin
        gap_count = '0;
        counting  = 1'b1;
        if (link_mode == MODE_CODE_FRAMESTART || link_mode == MODE_CODE_RECEIVING) begin
          if (late || fe || pe || committed + pending >= STORE_DEPTH) begin
            wr_ptr     = wr_ptr - PTR_W'(pending);
            pending    = 0;
            link_mode  = MODE_CODE_ROUNDTRIP;
            late       = 1'b0;
            st.dropped = 1'b1;
          end else if (link_mode == MODE_CODE_RECEIVING || data == addr_reg) begin
            frame_mem[wr_ptr] = data;
            wr_ptr    = wr_ptr + 1'b1;
            pending++;
            link_mode = MODE_CODE_RECEIVING;
          end else begin
            link_mode = MODE_CODE_ROUNDTRIP;
          end
        end
      end
      OP_TICK: begin
        if (counting) begin
          gap_count = gap_count + 1'b1;
          if (gap_count == gap_reg) begin
            late = 1'b1;
          end
          if (gap_count == idle_reg) begin
            st.done   = 1'b1;
            st.nbytes = CNT_W'(pending);
            committed += pending;
            pending   = 0;
            link_mode = MODE_CODE_FRAMESTART;
            counting  = 1'b0;
            late      = 1'b0;
          end
        end
      end
      OP_TX_BEGIN: begin
        if (link_mode == MODE_CODE_FRAMESTART) begin
          link_mode  = MODE_CODE_TRANSMIT;
          st.granted = 1'b1;
        end
      end
      OP_TX_END: begin
        if (link_mode == MODE_CODE_TRANSMIT) begin
          late      = 1'b0;
          gap_count = '0;
          counting  = 1'b1;
          link_mode = MODE_CODE_ROUNDTRIP;
        end
      end
      OP_READ: begin
        if (committed > 0) begin
          st.rvalid = 1'b1;
          st.rdata  = frame_mem[rd_ptr];
          rd_ptr    = rd_ptr + 1'b1;
          committed--;
        end
      end
      OP_CLEAR: begin
        committed = 0;
        pending   = 0;
        rd_ptr    = '0;
        wr_ptr    = '0;
      end
      default: begin
      end
    endcase
    st.mode  = link_mode;
    st.avail = CNT_W'(committed);
  endtask

  always @(posedge clk) begin
    framer_status_t want;
    framer_status_t got;
    if (!rst_n) begin
      restore_reset_state();
      predicted_status_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{mode: out_mode, done: out_frame_done, nbytes: out_frame_bytes,
                dropped: out_frame_dropped, granted: out_tx_granted,
                rvalid: out_read_valid, rdata: out_read_data, avail: out_available};
        if (predicted_status_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%t: result with nothing expected: %s", $realtime, show(got));
          end
          fail_count++;
        end else begin
          want = predicted_status_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%t: mismatch\n  expected %s\n  actual   %s", $realtime,
                       show(want), show(got));
            end
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLAVE_ADDR: addr_reg = cfg_data[7:0];
          CFG_GAP_LIMIT:  gap_reg  = cfg_data;
          CFG_IDLE_LIMIT: idle_reg = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_bus_event(in_op, in_rx_data, in_framing_error, in_parity_error, want);
        predicted_status_q.push_back(want);
      end
      outstanding <= predicted_status_q.size();
    end
  end

endmodule

@@ test/tb_modbus_rtu_slave_rx_framer_unit.sv @@
// Testbench top for the receive framer: clock, reset, stimulus, idling and the verdict.
module tb_modbus_rtu_slave_rx_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mrsf_pkg::*;

  localparam logic [2:0] OP_SPARE_LO   = 3'd6;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         PHASE_ITEMS   = 115;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_op;
  logic [7:0]       in_rx_data;
  logic             in_framing_error;
  logic             in_parity_error;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_mode;
  logic             out_frame_done;
  logic [CNT_W-1:0] out_frame_bytes;
  logic             out_frame_dropped;
  logic             out_tx_granted;
  logic             out_read_valid;
  logic [7:0]       out_read_data;
  logic [CNT_W-1:0] out_available;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;
  int               fail_count;
  int               outstanding;

  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  bit          hold_tgl      = 1'b0;
  bit          hold_seen     = 1'b0;
  int          hold_left     = 0;
  int          items_sent    = 0;
  logic [7:0]  cur_addr;
  logic [15:0] cur_gap;
  logic [15:0] cur_idle;

  modbus_rtu_slave_rx_framer_unit i_dut (.*);

  framer_checker i_checker (.*);

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_modbus_rtu_slave_rx_framer_unit: errors");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic fe,
                       input logic pe);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_op            = op;
    in_rx_data       = data;
    in_framing_error = fe;
    in_parity_error  = pe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic issue_plain(input logic [2:0] op);
    issue(op, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic receive_byte(input logic [7:0] data);
    issue(OP_RX_BYTE, data, 1'b0, 1'b0);
  endtask

  task automatic tick(input int n);
    repeat (n) issue_plain(OP_TICK);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [15:0] gap,
                            input logic [15:0] idle);
    write_reg(CFG_SLAVE_ADDR, {8'($urandom), addr});
    write_reg(CFG_GAP_LIMIT, gap);
    write_reg(CFG_IDLE_LIMIT, idle);
    cur_addr = addr;
    cur_gap  = gap;
    cur_idle = idle;
  endtask

  // Leaves the bus at frame start with the gap timer stopped.
  task automatic settle();
    issue_plain(OP_TX_END);
    tick(cur_idle);
    wait_results_done();
  endtask

  task automatic random_frame();
    int len;
    int spoil;
    int max_gap;
    int kind;
    tick(cur_idle);
    receive_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_addr);
    len     = $urandom_range(0, 10);
    spoil   = (len > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
    max_gap = (cur_gap < cur_idle) ? cur_gap : cur_idle;
    for (int i = 1; i <= len; i++) begin
      kind = $urandom_range(0, 3);
      if (i == spoil && kind == 0 && cur_gap < cur_idle) begin
        tick(cur_gap);
        receive_byte(8'($urandom));
      end else if (i == spoil) begin
        tick($urandom_range(0, max_gap - 1));
        issue(OP_RX_BYTE, 8'($urandom), kind != 2, kind >= 2);
      end else begin
        tick($urandom_range(0, max_gap - 1));
        receive_byte(8'($urandom));
      end
    end
    tick(cur_idle);
    if ($urandom_range(0, 9) < 6) begin
      repeat ($urandom_range(1, len + 2)) issue_plain(OP_READ);
    end
    if ($urandom_range(0, 4) == 0) begin
      issue_plain(OP_TX_BEGIN);
      if ($urandom_range(0, 1) == 0) begin
        receive_byte(8'($urandom));
      end
      issue_plain(OP_TX_END);
    end
  endtask

  task automatic random_noise();
    logic [2:0] op;
    op = 3'($urandom_range(OP_RX_BYTE, OP_SPARE_HI));
    if (op == OP_TICK) begin
      tick($urandom_range(1, cur_idle + 1));
    end else begin
      issue(op, 8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic random_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 65) begin
        random_frame();
      end else begin
        random_noise();
      end
      if ($urandom_range(0, 29) == 0) begin
        wait_results_done();
      end
    end
    settle();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_RX_BYTE;
    in_rx_data       = '0;
    in_framing_error = 1'b0;
    in_parity_error  = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_SLAVE_ADDR;
    cfg_data         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_config(8'h11, 16'd2, 16'd3);
    issue_plain(OP_READ);
    issue_plain(OP_TX_BEGIN);
    issue_plain(OP_TX_END);
    receive_byte(8'h11);
    tick(3);
    receive_byte(8'h00);
    tick(3);
    receive_byte(8'h11);
    receive_byte(8'hFF);
    tick(1);
    receive_byte(8'h00);
    tick(3);
    repeat (4) issue_plain(OP_READ);
    issue_plain(OP_TX_BEGIN);
    issue_plain(OP_TX_BEGIN);
    receive_byte(8'hA5);
    tick(1);
    issue_plain(OP_TX_END);
    tick(3);
    issue(OP_RX_BYTE, 8'h11, 1'b1, 1'b0);
    tick(3);
    receive_byte(8'h11);
    issue(OP_RX_BYTE, 8'h22, 1'b0, 1'b1);
    tick(3);
    receive_byte(8'h11);
    tick(2);
    receive_byte(8'h33);
    tick(3);
    receive_byte(8'h11);
    issue(OP_RX_BYTE, 8'h44, 1'b1, 1'b1);
    tick(3);
    receive_byte(8'h11);
    receive_byte(8'h55);
    tick(3);
    issue_plain(OP_CLEAR);
    issue_plain(OP_READ);
    issue_plain(OP_SPARE_LO);
    issue_plain(OP_SPARE_HI);
    settle();

    // Fill the store to the brim, overflow it, then drain it until its read pointer wraps.
    src_idle_pct = 64;
    set_config(8'hFF, 16'd2, 16'd3);
    receive_byte(8'hFF);
    repeat (299) receive_byte(8'($urandom));
    tick(3);
    receive_byte(8'hFF);
    repeat (211) receive_byte(8'($urandom));
    receive_byte(8'($urandom));
    tick(3);
    receive_byte(8'hFF);
    repeat (211) receive_byte(8'($urandom));
    tick(3);
    receive_byte(8'hFF);
    tick(3);
    issue_plain(OP_CLEAR);
    receive_byte(8'hFF);
    repeat (511) receive_byte(8'($urandom));
    tick(3);
    repeat (STORE_DEPTH + 1) issue_plain(OP_READ);
    settle();

    src_idle_pct = 0;
    set_config(8'h00, 16'hFFFF, 16'hFFFF);
    receive_byte(8'h00);
    receive_byte(8'hFF);
    receive_byte(8'h0F);
    tick(16'hFFFF);
    repeat (2) issue_plain(OP_READ);
    wait_results_done();

    set_config(8'($urandom), 16'd3, 16'd7);
    hold_tgl = ~hold_tgl;
    tick(HOLD_CYCLES + 20);
    random_phase(PHASE_ITEMS);

    snk_stall_pct = 64;
    set_config(8'($urandom), 16'd5, 16'd9);
    random_phase(PHASE_ITEMS);

    src_idle_pct  = 17;
    snk_stall_pct = 17;
    set_config(8'($urandom), 16'd9, 16'd5);
    random_phase(PHASE_ITEMS);

    src_idle_pct  = 64;
    snk_stall_pct = 0;
    set_config(8'($urandom), 16'd1, 16'd1);
    random_phase(PHASE_ITEMS);

    if (fail_count == 0) begin
      $display("tb_modbus_rtu_slave_rx_framer_unit: clean");
    end else begin
      $display("tb_modbus_rtu_slave_rx_framer_unit: errors");
    end
    $finish;
  end

endmodule
